>>> rtl/pvbd_pkg.sv
// shared types, codes and slot base table for the video bus decoder
package pvbd_pkg;

  localparam int NAMETABLE_BYTES_DEF = 4096;

  localparam logic [13:0] ADDR_MASK      = 14'h3fff;
  localparam logic [13:0] NT_START       = 14'h2000;
  localparam logic [13:0] PAL_START      = 14'h3f00;
  localparam logic [11:0] NT_FOLD_MASK   = 12'hfff;
  localparam logic [11:0] SLOT_OFS_MASK  = 12'h3ff;
  localparam logic [11:0] SLOT_BASE_1    = 12'h400;
  localparam logic [11:0] SLOT_BASE_2    = 12'h800;
  localparam logic [11:0] SLOT_BASE_3    = 12'hc00;

  localparam logic [1:0] REGION_PATTERN = 2'd0;
  localparam logic [1:0] REGION_NT      = 2'd1;
  localparam logic [1:0] REGION_PAL     = 2'd2;

  localparam logic [2:0] MODE_HORIZ     = 3'd0;
  localparam logic [2:0] MODE_VERT      = 3'd1;
  localparam logic [2:0] MODE_FOUR      = 3'd2;
  localparam logic [2:0] MODE_ONE_LOWER = 3'd3;
  localparam logic [2:0] MODE_ONE_UPPER = 3'd4;

  localparam logic FUNC_WRITE = 1'b1;

  typedef struct packed {
    logic [1:0]  region;
    logic [4:0]  pal_idx;
    logic [12:0] pat_addr;
  } dec_t;

  function automatic logic [11:0] slot_base(input logic [2:0] mode, input logic [1:0] slot);
    logic [11:0] base;
    base = 12'h000;
    unique case (mode)
      MODE_HORIZ:     base = slot[1] ? SLOT_BASE_1 : 12'h000;
      MODE_VERT:      base = slot[0] ? SLOT_BASE_1 : 12'h000;
      MODE_FOUR:      base = {slot, 10'h000};
      MODE_ONE_LOWER: base = 12'h000;
      MODE_ONE_UPPER: base = SLOT_BASE_1;
      default:        base = 12'h000;
    endcase
    return base;
  endfunction

endpackage

>>> rtl/ppu_video_bus_decoder_unit.sv
// video bus decoder top level: input register, ram access, result register
// path: an accepted word is held in the input register, then its result in the result
//   register drives the out_ ports, where the receiver takes it
// throughput: one word per cycle while busy is low, set by the single-port name-table ram
// reset: after rst_n, busy stays high while all NAMETABLE_BYTES entries of the
//   name-table ram are zeroed one entry a cycle; palette and counter clear at once
// the receiver cannot stall: out_strobe is high for exactly one cycle per word
module ppu_video_bus_decoder_unit #(
  parameter int NAMETABLE_BYTES = pvbd_pkg::NAMETABLE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  output logic        out_strobe,
  output logic [1:0]  out_region,
  output logic [7:0]  out_read_byte,
  output logic [12:0] out_pattern_address,
  output logic        out_pattern_write,
  output logic [7:0]  out_pattern_write_byte,
  output logic [31:0] out_write_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata
);

  localparam int NT_AW = $clog2(NAMETABLE_BYTES);

  logic [2:0]        mode_r;
  logic              clr_r;
  logic [NT_AW-1:0]  clr_idx_r;

  logic              in_v_r;
  logic              func_r;
  logic [13:0]       addr_r;
  logic [7:0]        data_r;

  pvbd_pkg::dec_t    dec;
  logic [NT_AW-1:0]  nt_idx;

  logic [7:0]        nt_mem [NAMETABLE_BYTES];
  logic [7:0]        pal_r  [32];
  logic [7:0]        nt_q_r;
  logic [7:0]        pal_q_r;

  logic              ram_we;
  logic [NT_AW-1:0]  ram_addr;
  logic [7:0]        ram_wdata;
  logic              is_wr;
  logic              cnt_inc;
  logic [31:0]       count_r;
  logic [31:0]       count_nxt;

  logic              out_v_r;
  logic [1:0]        region_r;
  logic              rd_r;
  logic [12:0]       pat_addr_r;
  logic              pat_wr_r;
  logic [7:0]        pat_byte_r;

  assign busy = clr_r;

  pvbd_decode #(
    .NT_BYTES(NAMETABLE_BYTES)
  ) u_decode (
    .addr   (addr_r),
    .mode   (mode_r),
    .dec    (dec),
    .nt_idx (nt_idx)
  );

  always_comb begin
    is_wr     = in_v_r && (func_r == pvbd_pkg::FUNC_WRITE);
    cnt_inc   = is_wr && (dec.region != pvbd_pkg::REGION_PAL);
    count_nxt = count_r + (cnt_inc ? 32'd1 : 32'd0);
    ram_we    = clr_r || (is_wr && (dec.region == pvbd_pkg::REGION_NT));
    ram_addr  = clr_r ? clr_idx_r : nt_idx;
    ram_wdata = clr_r ? 8'd0 : data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= pvbd_pkg::MODE_HORIZ;
      clr_r     <= 1'b1;
      clr_idx_r <= '0;
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      count_r   <= 32'd0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + NT_AW'(1);
        if (clr_idx_r == NT_AW'(NAMETABLE_BYTES - 1)) begin
          clr_r <= 1'b0;
        end
      end
      in_v_r  <= start && !busy;
      out_v_r <= in_v_r;
      count_r <= count_nxt;
    end
  end

  // palette storage, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        pal_r[i] <= 8'd0;
      end
    end else if (is_wr && (dec.region == pvbd_pkg::REGION_PAL)) begin
      pal_r[dec.pal_idx] <= data_r;
    end
  end

  always_ff @(posedge clk) begin
    pal_q_r <= pal_r[dec.pal_idx];
  end

  // name-table ram, single port
  always_ff @(posedge clk) begin
    if (ram_we) begin
      nt_mem[ram_addr] <= ram_wdata;
    end
    nt_q_r <= nt_mem[ram_addr];
  end

  always_ff @(posedge clk) begin
    func_r     <= in_func;
    addr_r     <= in_bus_address[13:0] & pvbd_pkg::ADDR_MASK;
    data_r     <= in_write_byte;
    region_r   <= dec.region;
    rd_r       <= !is_wr && (dec.region != pvbd_pkg::REGION_PATTERN);
    pat_addr_r <= dec.pat_addr;
    pat_wr_r   <= is_wr && (dec.region == pvbd_pkg::REGION_PATTERN);
    pat_byte_r <= (is_wr && (dec.region == pvbd_pkg::REGION_PATTERN)) ? data_r : 8'd0;
  end

  assign out_strobe             = out_v_r;
  assign out_region             = region_r;
  assign out_read_byte          = !rd_r ? 8'd0 :
                                  (region_r == pvbd_pkg::REGION_NT) ? nt_q_r : pal_q_r;
  assign out_pattern_address    = pat_addr_r;
  assign out_pattern_write      = pat_wr_r;
  assign out_pattern_write_byte = pat_byte_r;
  assign out_write_count        = count_r;

  a_accept_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> in_v_r)
    else $error("accepted word did not enter the input register");

  a_stage_to_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |=> out_strobe)
    else $error("word in the input register did not produce a result");

  a_no_word_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_v_r)
    else $error("word in flight while name-table ram is being cleared");

  a_pattern_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_region == pvbd_pkg::REGION_PATTERN)) |-> (out_read_byte == 8'd0))
    else $error("pattern space result carries read data");

  a_pattern_write_region: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_pattern_write) |-> (out_region == pvbd_pkg::REGION_PATTERN))
    else $error("pattern write flagged outside pattern space");

endmodule

>>> rtl/pvbd_decode.sv
// address decode: region, mirrored name-table index, palette index and pattern address
module pvbd_decode #(
  parameter int NT_BYTES = pvbd_pkg::NAMETABLE_BYTES_DEF,
  localparam int NT_AW = $clog2(NT_BYTES)
) (
  input  logic [13:0]      addr,
  input  logic [2:0]       mode,
  output pvbd_pkg::dec_t   dec,
  output logic [NT_AW-1:0] nt_idx
);

  logic [11:0] folded;
  logic [11:0] base;
  logic [12:0] sum;
  logic [12:0] wrapped;
  logic [4:0]  pal;

  always_comb begin
    folded = addr[11:0] & pvbd_pkg::NT_FOLD_MASK;
    base   = pvbd_pkg::slot_base(mode, folded[11:10]);
    sum    = {1'b0, base} + {1'b0, folded & pvbd_pkg::SLOT_OFS_MASK};
    wrapped = sum;
    if (sum >= 13'(NT_BYTES)) begin
      wrapped = sum - 13'(NT_BYTES);
    end
    if (wrapped >= 13'(NT_BYTES)) begin
      wrapped = 13'd0;
    end
    nt_idx = wrapped[NT_AW-1:0];

    pal = addr[4:0];
    if ((pal & 5'h13) == 5'h10) begin
      pal = pal & 5'h0f;
    end

    dec.pal_idx  = pal;
    dec.pat_addr = 13'd0;
    if (addr < pvbd_pkg::NT_START) begin
      dec.region   = pvbd_pkg::REGION_PATTERN;
      dec.pat_addr = addr[12:0];
    end else if (addr < pvbd_pkg::PAL_START) begin
      dec.region = pvbd_pkg::REGION_NT;
    end else begin
      dec.region = pvbd_pkg::REGION_PAL;
    end
  end

endmodule
